// ===== sv/flood_duplicate_filter_macros.svh =====
// Assertion macros for the flood duplicate filter checker.
// Used by fdf_checker.sv; no other dependencies.
`ifndef FLOOD_DUPLICATE_FILTER_MACROS_SVH
`define FLOOD_DUPLICATE_FILTER_MACROS_SVH

// same-cycle implication
`define FDF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication
`define FDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== sv/fdf_pkg.sv =====
// Shared types and constants for the flood duplicate filter.
// No dependencies; imported by every other file of the block except the macros header.
package fdf_pkg;

  localparam int unsigned SRC_W = 8;
  localparam int unsigned SEQ_W = 16;
  localparam int unsigned PAY_W = 32;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned ID_W  = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic REG_IDX_OWN_ID = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CNT,
    ST_SCAN,
    ST_DECIDE
  } fdf_state_e;

  typedef struct packed {
    logic [SRC_W-1:0] src_node;
    logic [SEQ_W-1:0] seq_in;
    logic [PAY_W-1:0] payload_in;
  } fdf_item_t;

  typedef struct packed {
    logic             do_forward;
    logic [ID_W-1:0]  fwd_source;
    logic [SEQ_W-1:0] fwd_sequence;
    logic [PAY_W-1:0] fwd_payload;
    logic [CNT_W-1:0] src_count;
    logic             bad_source;
    logic             table_full;
  } fdf_res_t;

endpackage

// ===== sv/fdf_if.sv =====
// Valid/ready channel interfaces for received packets and filter results.
// Depends on fdf_pkg for field widths.
interface fdf_in_if import fdf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SRC_W-1:0] src_node;
  logic [SEQ_W-1:0] seq_in;
  logic [PAY_W-1:0] payload_in;

  modport source (output valid, src_node, seq_in, payload_in, input ready);
  modport sink   (input valid, src_node, seq_in, payload_in, output ready);
endinterface

interface fdf_out_if import fdf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             do_forward;
  logic [ID_W-1:0]  fwd_source;
  logic [SEQ_W-1:0] fwd_sequence;
  logic [PAY_W-1:0] fwd_payload;
  logic [CNT_W-1:0] src_count;
  logic             bad_source;
  logic             table_full;

  modport source (output valid, do_forward, fwd_source, fwd_sequence, fwd_payload,
                  src_count, bad_source, table_full, input ready);
  modport sink   (input valid, do_forward, fwd_source, fwd_sequence, fwd_payload,
                  src_count, bad_source, table_full, output ready);
endinterface

// ===== sv/fdf_cnt_mem.sv =====
// Per-source packet count memory with per-entry valid bits (unwritten reads as zero).
// Depends on fdf_pkg.
module fdf_cnt_mem import fdf_pkg::*; #(
  parameter int unsigned NODE_COUNT = 16,
  localparam int unsigned NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic             wr_en_i,
  input  logic [NW-1:0]    idx_i,
  input  logic [CNT_W-1:0] wr_data_i,
  output logic [CNT_W-1:0] rd_data_o
);

  logic [CNT_W-1:0]      mem_q [NODE_COUNT];
  logic [NODE_COUNT-1:0] vld_q;
  logic [CNT_W-1:0]      rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[idx_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= vld_q[idx_i] ? mem_q[idx_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/fdf_seen_mem.sv =====
// Seen-payload memory: one write port, one registered read port.
// Depends on fdf_pkg.
module fdf_seen_mem import fdf_pkg::*; #(
  parameter int unsigned SEEN_DEPTH = 64,
  localparam int unsigned AW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [PAY_W-1:0] wr_data_i,
  output logic [PAY_W-1:0] rd_data_o
);

  logic [PAY_W-1:0] mem_q [SEEN_DEPTH];
  logic [PAY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/fdf_ctrl.sv =====
// Sequencer: count read-modify-write, seen-table scan and record, result build.
// Depends on fdf_pkg; drives fdf_cnt_mem and fdf_seen_mem.
module fdf_ctrl import fdf_pkg::*; #(
  parameter int unsigned SEEN_DEPTH = 64,
  parameter int unsigned NODE_COUNT = 16,
  localparam int unsigned AW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1,
  localparam int unsigned UW = $clog2(SEEN_DEPTH + 1),
  localparam int unsigned NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  fdf_item_t        item_i,
  input  logic [ID_W-1:0]  own_id_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output fdf_res_t         res_o,
  output logic             cnt_rd_en_o,
  output logic             cnt_wr_en_o,
  output logic [NW-1:0]    cnt_idx_o,
  output logic [CNT_W-1:0] cnt_wr_data_o,
  input  logic [CNT_W-1:0] cnt_rd_data_i,
  output logic             seen_rd_en_o,
  output logic [AW-1:0]    seen_rd_addr_o,
  output logic             seen_wr_en_o,
  output logic [AW-1:0]    seen_wr_addr_o,
  output logic [PAY_W-1:0] seen_wr_data_o,
  input  logic [PAY_W-1:0] seen_rd_data_i
);

  fdf_state_e       state_q, state_d;
  fdf_item_t        item_q, item_d;
  logic             in_range_q, in_range_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [UW-1:0]    ptr_q, ptr_d;
  logic [UW-1:0]    used_q, used_d;
  logic             found_q, found_d;
  logic             hit;
  logic             scan_end;
  logic             has_room;
  logic [CNT_W-1:0] cnt_inc;

  assign hit      = (seen_rd_data_i == item_q.payload_in);
  assign scan_end = (ptr_q == used_q);
  assign has_room = (used_q < UW'(SEEN_DEPTH));
  assign cnt_inc  = (cnt_rd_data_i == CNT_MAX) ? CNT_MAX : cnt_rd_data_i + CNT_W'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) state_d = ST_CNT;
      end
      ST_CNT: begin
        state_d = (used_q == '0) ? ST_DECIDE : ST_SCAN;
      end
      ST_SCAN: begin
        if (hit || scan_end) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready_o   = 1'b0;
    res_valid_o    = 1'b0;
    cnt_rd_en_o    = 1'b0;
    cnt_wr_en_o    = 1'b0;
    cnt_idx_o      = item_q.src_node[NW-1:0];
    cnt_wr_data_o  = cnt_inc;
    seen_rd_en_o   = 1'b0;
    seen_rd_addr_o = ptr_q[AW-1:0];
    seen_wr_en_o   = 1'b0;
    seen_wr_addr_o = used_q[AW-1:0];
    seen_wr_data_o = item_q.payload_in;
    unique case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        cnt_rd_en_o  = item_valid_i;
        cnt_idx_o    = item_i.src_node[NW-1:0];
      end
      ST_CNT: begin
        cnt_wr_en_o    = in_range_q;
        seen_rd_en_o   = (used_q != '0);
        seen_rd_addr_o = '0;
      end
      ST_SCAN: begin
        seen_rd_en_o = !hit && !scan_end;
      end
      ST_DECIDE: begin
        res_valid_o  = 1'b1;
        seen_wr_en_o = res_ready_i && !found_q && has_room;
      end
      default: ;
    endcase
  end

  always_comb begin
    item_d     = item_q;
    in_range_d = in_range_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    used_d     = used_q;
    found_d    = found_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_d     = item_i;
          in_range_d = ({1'b0, item_i.src_node} < (SRC_W + 1)'(NODE_COUNT));
        end
      end
      ST_CNT: begin
        count_d = in_range_q ? cnt_inc : '0;
        found_d = 1'b0;
        ptr_d   = UW'(1);
      end
      ST_SCAN: begin
        if (hit) begin
          found_d = 1'b1;
        end else if (!scan_end) begin
          ptr_d = ptr_q + UW'(1);
        end
      end
      ST_DECIDE: begin
        if (res_ready_i && !found_q && has_room) used_d = used_q + UW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o              = '0;
    res_o.src_count    = count_q;
    res_o.bad_source   = !in_range_q;
    if (!found_q) begin
      res_o.do_forward   = 1'b1;
      res_o.fwd_source   = own_id_i;
      res_o.fwd_sequence = (item_q.seq_in == SEQ_MAX) ? SEQ_MAX
                                                      : item_q.seq_in + SEQ_W'(1);
      res_o.fwd_payload  = item_q.payload_in;
      res_o.table_full   = !has_room;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      used_q     <= '0;
      ptr_q      <= '0;
      found_q    <= 1'b0;
      in_range_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      ptr_q      <= ptr_d;
      found_q    <= found_d;
      in_range_q <= in_range_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    count_q <= count_d;
  end

endmodule

// ===== sv/flood_duplicate_filter.sv =====
// Duplicate filter for a flooding node. One received packet is handled at a time. The
// scan reads the seen-payload memory (at most SEEN_DEPTH recorded payloads) through its
// one read port and compares one entry per cycle. A matching entry ends the scan early;
// a result still waiting in the output register holds the sequencer until the receiver
// takes it. After the scan ends the sequencer presents the result in its decide state,
// and the result then waits in an output register. No clearing pass runs after reset;
// the per-source counts start from zero through valid bits.
// Depends on fdf_pkg, fdf_if, fdf_cnt_mem, fdf_seen_mem and fdf_ctrl.
module flood_duplicate_filter import fdf_pkg::*; #(
  parameter int unsigned SEEN_DEPTH = 64,
  parameter int unsigned NODE_COUNT = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fdf_in_if.sink            in_i,
  fdf_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned AW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
  localparam int unsigned NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  logic [ID_W-1:0]  own_id_q;
  logic             out_valid_q;
  fdf_res_t         out_q;
  fdf_item_t        item;
  fdf_res_t         res;
  logic             res_valid;
  logic             res_ready;
  logic             cnt_rd_en;
  logic             cnt_wr_en;
  logic [NW-1:0]    cnt_idx;
  logic [CNT_W-1:0] cnt_wr_data;
  logic [CNT_W-1:0] cnt_rd_data;
  logic             seen_rd_en;
  logic [AW-1:0]    seen_rd_addr;
  logic             seen_wr_en;
  logic [AW-1:0]    seen_wr_addr;
  logic [PAY_W-1:0] seen_wr_data;
  logic [PAY_W-1:0] seen_rd_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDX_OWN_ID) ? APB_DW'(own_id_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_IDX_OWN_ID)) begin
      own_id_q <= pwdata[ID_W-1:0];
    end
  end

  assign item.src_node   = in_i.src_node;
  assign item.seq_in     = in_i.seq_in;
  assign item.payload_in = in_i.payload_in;

  fdf_ctrl #(
    .SEEN_DEPTH(SEEN_DEPTH),
    .NODE_COUNT(NODE_COUNT)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (in_i.valid),
    .item_ready_o   (in_i.ready),
    .item_i         (item),
    .own_id_i       (own_id_q),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .cnt_rd_en_o    (cnt_rd_en),
    .cnt_wr_en_o    (cnt_wr_en),
    .cnt_idx_o      (cnt_idx),
    .cnt_wr_data_o  (cnt_wr_data),
    .cnt_rd_data_i  (cnt_rd_data),
    .seen_rd_en_o   (seen_rd_en),
    .seen_rd_addr_o (seen_rd_addr),
    .seen_wr_en_o   (seen_wr_en),
    .seen_wr_addr_o (seen_wr_addr),
    .seen_wr_data_o (seen_wr_data),
    .seen_rd_data_i (seen_rd_data)
  );

  fdf_cnt_mem #(
    .NODE_COUNT(NODE_COUNT)
  ) u_cnt_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (cnt_rd_en),
    .wr_en_i   (cnt_wr_en),
    .idx_i     (cnt_idx),
    .wr_data_i (cnt_wr_data),
    .rd_data_o (cnt_rd_data)
  );

  fdf_seen_mem #(
    .SEEN_DEPTH(SEEN_DEPTH)
  ) u_seen_mem (
    .clk_i     (clk_i),
    .rd_en_i   (seen_rd_en),
    .rd_addr_i (seen_rd_addr),
    .wr_en_i   (seen_wr_en),
    .wr_addr_i (seen_wr_addr),
    .wr_data_i (seen_wr_data),
    .rd_data_o (seen_rd_data)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.do_forward   = out_q.do_forward;
  assign out_o.fwd_source   = out_q.fwd_source;
  assign out_o.fwd_sequence = out_q.fwd_sequence;
  assign out_o.fwd_payload  = out_q.fwd_payload;
  assign out_o.src_count    = out_q.src_count;
  assign out_o.bad_source   = out_q.bad_source;
  assign out_o.table_full   = out_q.table_full;

endmodule

// ===== sv/fdf_checker.sv =====
// Port-level checker for flood_duplicate_filter, bound to the top level.
// Depends on fdf_pkg and flood_duplicate_filter_macros.svh.
`include "flood_duplicate_filter_macros.svh"

module fdf_checker import fdf_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             do_forward_i,
  input logic [ID_W-1:0]  fwd_source_i,
  input logic [SEQ_W-1:0] fwd_sequence_i,
  input logic [PAY_W-1:0] fwd_payload_i,
  input logic [CNT_W-1:0] src_count_i,
  input logic             bad_source_i,
  input logic             table_full_i
);

  `FDF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable({do_forward_i, fwd_source_i, fwd_sequence_i, fwd_payload_i, src_count_i, bad_source_i, table_full_i}))
  `FDF_ASSERT_IMPL(a_drop_zero, clk_i, rst_ni, out_valid_i && !do_forward_i, fwd_source_i == '0 && fwd_sequence_i == '0 && fwd_payload_i == '0 && !table_full_i)
  `FDF_ASSERT_IMPL(a_bad_src_cnt, clk_i, rst_ni, out_valid_i && bad_source_i, src_count_i == '0)
  `FDF_ASSERT_NEXT(a_one_at_time, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

endmodule

bind flood_duplicate_filter fdf_checker u_fdf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .do_forward_i   (out_o.do_forward),
  .fwd_source_i   (out_o.fwd_source),
  .fwd_sequence_i (out_o.fwd_sequence),
  .fwd_payload_i  (out_o.fwd_payload),
  .src_count_i    (out_o.src_count),
  .bad_source_i   (out_o.bad_source),
  .table_full_i   (out_o.table_full)
);
